@@ hdl/lbcht_pkg.sv @@
// ----------------------------------------------------------------------------
// lbcht_pkg
// Shared types and constants for the LRU block cache hit tracker.
// ----------------------------------------------------------------------------
package lbcht_pkg;

   localparam int BLOCK_W = 32;
   localparam int FRAMES_W = 7;
   localparam int TOTAL_W = 32;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd64;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Control broadcast from the sequencer to every cell of the stack.
   typedef struct packed {
      logic compare;   // capture the tag match against the pending item
      logic shift;     // apply the move-to-front update
   } cell_ctrl_type;

endpackage

@@ hdl/lbcht_cell.sv @@
// ----------------------------------------------------------------------------
// lbcht_cell
// One position of the recency stack: holds a tag, compares it against the
// pending item and takes its neighbor's tag when the stack shifts.
// ----------------------------------------------------------------------------
module lbcht_cell #(
   parameter int INDEX = 0,
   parameter int OCC_W = 7
) (
   input  logic                          clock,
   input  lbcht_pkg::cell_ctrl_type      ctrl,
   input  logic [lbcht_pkg::BLOCK_W-1:0] block,
   input  logic [OCC_W-1:0]              occupied,
   input  logic [lbcht_pkg::BLOCK_W-1:0] prev_tag,
   input  logic                          hit_seen_in,
   output logic [lbcht_pkg::BLOCK_W-1:0] tag,
   output logic                          hit_seen_out
);

   logic [lbcht_pkg::BLOCK_W-1:0] tag_ff;
   logic                          match_ff;
   logic                          match_in;

   // Only positions below the occupancy hold written tags.
   assign match_in = (tag_ff == block) && (OCC_W'(INDEX) < occupied);

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         match_ff <= match_in;
      end
      // A cell moves only if no hit was found closer to the front.
      if (ctrl.shift && !hit_seen_in) begin
         tag_ff <= prev_tag;
      end
   end

   assign tag = tag_ff;
   assign hit_seen_out = hit_seen_in | match_ff;

endmodule

@@ hdl/lru_block_cache_hit_tracker.sv @@
// ----------------------------------------------------------------------------
// lru_block_cache_hit_tracker
// Fully associative LRU block cache that reports hits and a saturating hit
// total. For each item, first every cell of the recency stack compares its
// tag with the block number; then the stack shifts the hit entry (or the new
// block on a miss) to the front and the result is registered. A new item is
// accepted during that update step, so the block can take a new item before
// it is through with the last one while the result side keeps up.
// A finished result waits in an output register; the update stalls only while
// that register is full and stalled. The CSR limit is clamped to 1..CAPACITY
// and takes effect on the next miss. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lru_block_cache_hit_tracker #(
   parameter int CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lbcht_pkg::FRAMES_W-1:0]        csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lbcht_pkg::BLOCK_W-1:0]         req_block_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [lbcht_pkg::BLOCK_W-1:0]         rsp_hit_block,
   output logic [lbcht_pkg::TOTAL_W-1:0]         rsp_hit_total
);

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CW = (OCC_W > lbcht_pkg::FRAMES_W) ? OCC_W : lbcht_pkg::FRAMES_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   state_type                       state_ff;
   logic [lbcht_pkg::FRAMES_W-1:0]  frames_ff;
   logic [OCC_W-1:0]                occ_ff;
   logic [OCC_W-1:0]                occ_in;
   logic [lbcht_pkg::TOTAL_W-1:0]   count_ff;
   logic [lbcht_pkg::TOTAL_W-1:0]   count_in;
   logic [lbcht_pkg::BLOCK_W-1:0]   block_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [lbcht_pkg::BLOCK_W-1:0]   rsp_block_ff;
   logic [lbcht_pkg::TOTAL_W-1:0]   rsp_total_ff;

   logic                            can_update;
   logic                            accept;
   logic                            hit;
   lbcht_pkg::cell_ctrl_type        ctrl;

   logic [CW-1:0]                   frames_ext;
   logic [CW-1:0]                   limit;
   logic [CW-1:0]                   kept;

   logic [lbcht_pkg::BLOCK_W-1:0]   tag_chain [CAPACITY];
   logic                            seen_chain [CAPACITY+1];

   assign can_update = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_UPD) && can_update));
   assign accept = req_valid && !req_stall;

   assign ctrl.compare = (state_ff == ST_CMP);
   assign ctrl.shift = (state_ff == ST_UPD) && can_update;

   assign seen_chain[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [lbcht_pkg::BLOCK_W-1:0] prev_tag;
         if (gi == 0) begin : g_head
            assign prev_tag = block_ff;
         end else begin : g_body
            assign prev_tag = tag_chain[gi-1];
         end
         lbcht_cell #(
            .INDEX (gi),
            .OCC_W (OCC_W)
         ) u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .block        (block_ff),
            .occupied     (occ_ff),
            .prev_tag     (prev_tag),
            .hit_seen_in  (seen_chain[gi]),
            .tag          (tag_chain[gi]),
            .hit_seen_out (seen_chain[gi+1])
         );
      end
   endgenerate

   assign hit = seen_chain[CAPACITY];

   // Effective frame limit, clamped to 1..CAPACITY.
   always_comb begin
      frames_ext = CW'(frames_ff);
      if (frames_ext == '0) begin
         limit = CW'(1);
      end else if (frames_ext > CW'(CAPACITY)) begin
         limit = CW'(CAPACITY);
      end else begin
         limit = frames_ext;
      end
      kept = CW'(occ_ff);
      if (kept >= limit) begin
         kept = limit - CW'(1);
      end
      occ_in = OCC_W'(kept + CW'(1));
      count_in = (count_ff == lbcht_pkg::TOTAL_MAX) ? count_ff : count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         frames_ff <= lbcht_pkg::FRAMES_RESET;
         occ_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end
         // A new result in the same cycle keeps the register full.
         if (rsp_valid_ff && !rsp_stall && !ctrl.shift) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (can_update) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff <= hit;
                  rsp_block_ff <= hit ? block_ff : '0;
                  if (hit) begin
                     count_ff <= count_in;
                     rsp_total_ff <= count_in;
                  end else begin
                     occ_ff <= occ_in;
                     rsp_total_ff <= count_ff;
                  end
                  state_ff <= accept ? ST_CMP : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The pending block is captured on accept; the stack shift in the same
   // cycle still reads the previous block.
   always_ff @(posedge clock) begin
      if (accept) begin
         block_ff <= req_block_number;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_hit_block = rsp_block_ff;
   assign rsp_hit_total = rsp_total_ff;

endmodule

@@ hdl/lbcht_checker.sv @@
// ----------------------------------------------------------------------------
// lbcht_checker
// Port-level checks for the LRU block cache hit tracker, bound to the top.
// ----------------------------------------------------------------------------
module lbcht_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_hit,
   input logic [lbcht_pkg::BLOCK_W-1:0]         rsp_hit_block,
   input logic [lbcht_pkg::TOTAL_W-1:0]         rsp_hit_total
);

   // A miss never echoes a block number.
   a_miss_block_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_block == '0)
      else $error("miss item carries a nonzero hit_block");

   // A hit always leaves a nonzero total behind it.
   a_hit_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_total != '0)
      else $error("hit item with a zero hit_total");

   // Each item goes through the compare step in the stack before the next one enters.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted in the compare cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_total))
      else $error("stalled result item changed");

endmodule

bind lru_block_cache_hit_tracker lbcht_checker u_lbcht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_hit       (rsp_hit),
   .rsp_hit_block (rsp_hit_block),
   .rsp_hit_total (rsp_hit_total)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU block cache hit tracker testbench
// Streams block numbers into the cache through the valid/stall channel and
// predicts every response with a private LRU stack. The frame limit is changed
// between phases while the block is drained. Both sides idle at random, and
// the response side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAPACITY = 64;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int RANDOM_PHASES = 10;

   typedef struct packed {
      logic                          hit;
      logic [lbcht_pkg::BLOCK_W-1:0] block;
      logic [lbcht_pkg::TOTAL_W-1:0] total;
   } lookup_result_type;

   // Tracks the recency stack and checks responses in order.
   class hit_tracker_scoreboard;
      logic [lbcht_pkg::BLOCK_W-1:0]  tags[CAPACITY];
      int unsigned                    occupied;
      logic [lbcht_pkg::TOTAL_W-1:0]  hit_count;
      logic [lbcht_pkg::FRAMES_W-1:0] frames;
      lookup_result_type              expected_lookups[$];
      int                             errors;
      int                             checked;
      int                             hits_seen;

      function void reset_state();
         foreach (tags[i]) tags[i] = '0;
         occupied  = 0;
         hit_count = '0;
         frames    = lbcht_pkg::FRAMES_RESET;
         expected_lookups.delete();
      endfunction

      function void set_frames(input logic [lbcht_pkg::FRAMES_W-1:0] value);
         frames = value;
      endfunction

      function int pending();
         return expected_lookups.size();
      endfunction

      function void note_block(input logic [lbcht_pkg::BLOCK_W-1:0] blk);
         int unsigned       pos;
         int unsigned       n;
         int unsigned       lim;
         lookup_result_type res;
         pos = occupied;
         for (int unsigned i = 0; i < occupied; i++) begin
            if (pos == occupied && tags[i] == blk) pos = i;
         end
         if (pos < occupied) begin
            for (int unsigned i = pos; i > 0; i--) tags[i] = tags[i-1];
            tags[0] = blk;
            if (hit_count != lbcht_pkg::TOTAL_MAX) hit_count = hit_count + 1'b1;
            res.hit   = 1'b1;
            res.block = blk;
         end else begin
            // A shrunken limit drops the oldest entries on the next miss.
            lim = (frames == 0) ? 1 : ((frames > CAPACITY) ? CAPACITY : frames);
            n = occupied;
            if (n >= lim) n = lim - 1;
            for (int unsigned i = n; i > 0; i--) tags[i] = tags[i-1];
            tags[0]  = blk;
            occupied = n + 1;
            res.hit   = 1'b0;
            res.block = '0;
         end
         res.total = hit_count;
         expected_lookups.push_back(res);
      endfunction

      function void check_result(input logic hit,
                                 input logic [lbcht_pkg::BLOCK_W-1:0] blk,
                                 input logic [lbcht_pkg::TOTAL_W-1:0] total);
         lookup_result_type exp_res;
         if (expected_lookups.size() == 0) begin
            $error("response with no item outstanding: hit %h block %h total %h",
                   hit, blk, total);
            errors++;
         end else begin
            exp_res = expected_lookups.pop_front();
            checked++;
            if (hit === 1'b1) hits_seen++;
            if (hit !== exp_res.hit) begin
               $error("hit mismatch: expected %h, actual %h", exp_res.hit, hit);
               errors++;
            end
            if (blk !== exp_res.block) begin
               $error("hit_block mismatch: expected %h, actual %h", exp_res.block, blk);
               errors++;
            end
            if (total !== exp_res.total) begin
               $error("hit_total mismatch: expected %h, actual %h", exp_res.total, total);
               errors++;
            end
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [lbcht_pkg::FRAMES_W-1:0] csr_wr_data;
   logic                           req_valid;
   logic                           req_stall;
   logic [lbcht_pkg::BLOCK_W-1:0]  req_block_number;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic                           rsp_hit;
   logic [lbcht_pkg::BLOCK_W-1:0]  rsp_hit_block;
   logic [lbcht_pkg::TOTAL_W-1:0]  rsp_hit_total;

   hit_tracker_scoreboard sb;
   bit no_idle;
   bit hold_request;
   int hold_left;
   int items_sent;
   int frame_writes;

   lru_block_cache_hit_tracker #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_number(req_block_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_hit_block   (rsp_hit_block),
      .rsp_hit_total   (rsp_hit_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: check each accepted item, then pick the next stall value.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_hit, rsp_hit_block, rsp_hit_total);
         if (hold_request) begin
            hold_left    = 300;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 19);
         end
      end
   end

   task automatic offer_block(input logic [lbcht_pkg::BLOCK_W-1:0] blk);
      while (!no_idle && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_block_number <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_block(blk);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_frames(input logic [lbcht_pkg::FRAMES_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_frames(value);
      frame_writes++;
   endtask

   // Most items come from a pool a bit larger than the frame limit so that
   // hits, deep moves and evictions all happen often.
   task automatic run_random_phase(input int count, input int pool_size, input int hold_at);
      logic [lbcht_pkg::BLOCK_W-1:0] pool[128];
      logic [lbcht_pkg::BLOCK_W-1:0] blk;
      int                            pick;
      for (int k = 0; k < pool_size; k++) pool[k] = $urandom;
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) hold_request = 1'b1;
         pick = $urandom_range(99);
         if (pick < 82)
            blk = pool[$urandom_range(pool_size - 1)];
         else if (pick < 94)
            blk = $urandom;
         else if (pick < 96)
            blk = '0;
         else if (pick < 98)
            blk = '1;
         else
            blk = pool[0] ^ (32'd1 << $urandom_range(lbcht_pkg::BLOCK_W - 1));
         offer_block(blk);
      end
   endtask

   initial begin
      logic [lbcht_pkg::FRAMES_W-1:0] phase_frames[RANDOM_PHASES];
      int                             lim;
      int                             pool_size;
      sb = new();
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_block_number = '0;
      no_idle          = 1'b0;
      hold_request     = 1'b0;
      hold_left        = 0;
      items_sent       = 0;
      frame_writes     = 0;
      sb.reset_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset limit; the cleared stack must not match block zero.
      offer_block(32'h0000_0000);
      offer_block(32'h0000_0000);
      offer_block(32'hFFFF_FFFF);
      offer_block(32'hFFFF_FFFF);
      offer_block(32'h0000_0000);
      offer_block(32'hAAAA_AAAA);
      offer_block(32'h5555_5555);
      offer_block(32'h0000_0000);
      offer_block(32'h0000_0001);
      // A single frame: every new block evicts the old one.
      write_frames(7'd1);
      offer_block(32'd5);
      offer_block(32'd5);
      offer_block(32'd6);
      offer_block(32'd5);
      // A limit of zero behaves like one.
      write_frames(7'd0);
      offer_block(32'd7);
      offer_block(32'd7);
      offer_block(32'd8);
      offer_block(32'd7);
      // A limit above the capacity is clamped.
      write_frames(7'd127);
      offer_block(32'd9);
      offer_block(32'd10);
      offer_block(32'd11);
      offer_block(32'd9);
      // Shrinking while occupied: a hit keeps the entries, the next miss trims.
      write_frames(7'd2);
      offer_block(32'd10);
      offer_block(32'd12);
      offer_block(32'd9);

      phase_frames[0] = 7'd64;
      phase_frames[1] = 7'd127;
      phase_frames[2] = 7'd2;
      phase_frames[3] = 7'd0;
      phase_frames[4] = 7'd8;
      phase_frames[5] = 7'd1;
      phase_frames[6] = 7'd16;
      phase_frames[7] = 7'($urandom_range(CAPACITY, 1));
      phase_frames[8] = 7'd40;
      phase_frames[9] = 7'd64;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_frames(phase_frames[p]);
         lim = (phase_frames[p] == 0) ? 1 :
               ((phase_frames[p] > CAPACITY) ? CAPACITY : phase_frames[p]);
         pool_size = lim + lim / 2 + 2;
         if (pool_size > 128) pool_size = 128;
         no_idle = (p == 6);
         run_random_phase(ITEMS_PER_PHASE, pool_size, (p == 1) ? 30 : -1);
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d blocks over %0d frame limits; %0d responses checked, %0d hits.",
               items_sent, frame_writes, sb.checked, sb.hits_seen);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d errors, %0d responses missing", sb.errors, sb.pending());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ lru_block_cache_hit_tracker.f @@
hdl/lbcht_pkg.sv
hdl/lbcht_cell.sv
hdl/lru_block_cache_hit_tracker.sv
hdl/lbcht_checker.sv
bench/testbench.sv
